>>> rtl/nca_pkg.sv
package nca_pkg;

  // field widths fixed by the item format
  localparam int COORD_BITS   = 16;
  localparam int CENTER_IDX_W = 4;
  localparam int CFG_W        = 5;

  // center store and lane count
  localparam int MAX_CENTERS = 16;
  localparam int ID_W        = $clog2(MAX_CENTERS);
  localparam int COUNT_W     = $clog2(MAX_CENTERS + 1);

  // distance arithmetic
  localparam int SQ_BITS   = 2 * COORD_BITS;
  localparam int DIST_BITS = SQ_BITS + 1;

  typedef enum logic {
    KIND_LOAD     = 1'b0,
    KIND_CLASSIFY = 1'b1
  } kind_e;

  // per-stage advance strobes shared by the datapath modules
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  // one contender in the minimum search
  typedef struct packed {
    logic                 ok;
    logic [ID_W-1:0]      id;
    logic [DIST_BITS-1:0] sq_dist;
  } cand_t;

  // lo always carries the lower index, so it keeps ties
  function automatic cand_t cand_min(cand_t lo, cand_t hi);
    cand_t res;
    res = lo;
    if (hi.ok && (!lo.ok || (hi.sq_dist < lo.sq_dist))) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

>>> rtl/nca_if.sv
interface nca_item_if import nca_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [CENTER_IDX_W-1:0] center_index;
  logic [COORD_BITS-1:0]   coord_x;
  logic [COORD_BITS-1:0]   coord_y;

  modport source (output valid, kind, center_index, coord_x, coord_y, input ready);
  modport sink   (input valid, kind, center_index, coord_x, coord_y, output ready);
endinterface

interface nca_result_if import nca_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ID_W-1:0]       nearest_id;
  logic [DIST_BITS-1:0]  min_distance;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;

  modport source (output valid, nearest_id, min_distance, point_x, point_y, input ready);
  modport sink   (input valid, nearest_id, min_distance, point_x, point_y, output ready);
endinterface

interface nca_cfg_if import nca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/nearest_center_assign_core.sv
// k-means assignment for 2-d points. a word on in_i with kind load writes the
// centre slot center_index with (coord_x, coord_y) and yields nothing; a word
// with kind classify yields one result word on out_o: the index of the nearest
// of the first num_centers centres by exact squared euclidean distance (lower
// index on a tie), that distance and the point itself. the pipeline takes one
// word every cycle while out_o is not stalled; a classify word passes through
// an input stage, then one lane per centre doing absolute difference,
// squaring and summing in three stages, then a two-stage registered minimum
// tree. back-pressure on out_o stalls only the stages that are full, so
// bubbles are squeezed out. num_centers is to be written on cfg_i only while
// the block is idle; the block itself does not enforce this. 0 behaves as 1
// and values above the store depth as the depth. classifying against a centre
// slot that was never loaded gives an undefined answer for that slot
module nearest_center_assign_core import nca_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  nca_cfg_if.sink      cfg_i,
  nca_item_if.sink     in_i,
  nca_result_if.source out_o
);

  localparam int Stages = 6;

  // pipeline control: valid bit and ready term per stage
  logic     v_q [Stages];
  logic     rdy [Stages];
  pipe_en_t pipe_en;

  // input stage payload
  logic                    kind_q;
  logic [CENTER_IDX_W-1:0] idx_q;
  logic [COORD_BITS-1:0]   pt_x_q [Stages];
  logic [COORD_BITS-1:0]   pt_y_q [Stages];

  // centre store, no reset: contents are defined once loaded
  logic [COORD_BITS-1:0] ctr_x_q [MAX_CENTERS];
  logic [COORD_BITS-1:0] ctr_y_q [MAX_CENTERS];
  logic                  store_we;

  // centre count register and its saturated form
  logic [CFG_W-1:0]   num_centers_q;
  logic [COUNT_W-1:0] count;
  logic               lane_on [MAX_CENTERS];

  logic [DIST_BITS-1:0] lane_dist [MAX_CENTERS];
  cand_t                leaf [MAX_CENTERS];
  cand_t                win;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_centers_q <= CFG_W'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      num_centers_q <= cfg_i.data;
    end
  end

  always_comb begin
    if (num_centers_q == '0) begin
      count = COUNT_W'(1);
    end else if (int'(num_centers_q) > MAX_CENTERS) begin
      count = COUNT_W'(MAX_CENTERS);
    end else begin
      count = COUNT_W'(num_centers_q);
    end
    for (int i = 0; i < MAX_CENTERS; i++) begin
      lane_on[i] = (COUNT_W'(i) < count);
    end
  end

  // a stage may load when it is empty or its successor moves on
  always_comb begin
    rdy[Stages-1] = !v_q[Stages-1] || out_o.ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_i.ready = rdy[0];
  assign pipe_en    = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5]};

  // valid bits; a load word drops out when it leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Stages; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_i.valid;
      end
      if (rdy[1]) begin
        v_q[1] <= v_q[0] && (kind_q == KIND_CLASSIFY);
      end
      for (int k = 2; k < Stages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // point payload travels beside the valid bits
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      kind_q    <= in_i.kind;
      idx_q     <= in_i.center_index;
      pt_x_q[0] <= in_i.coord_x;
      pt_y_q[0] <= in_i.coord_y;
    end
    for (int k = 1; k < Stages; k++) begin
      if (rdy[k]) begin
        pt_x_q[k] <= pt_x_q[k-1];
        pt_y_q[k] <= pt_y_q[k-1];
      end
    end
  end

  // loads write as they leave the input stage, so a classify word in the
  // same stage earlier has already read the old centre
  assign store_we = v_q[0] && (kind_q == KIND_LOAD) && rdy[1]
                    && (int'(idx_q) < MAX_CENTERS);

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      ctr_x_q[idx_q[ID_W-1:0]] <= pt_x_q[0];
      ctr_y_q[idx_q[ID_W-1:0]] <= pt_y_q[0];
    end
  end

  // one distance lane per centre slot
  for (genvar i = 0; i < MAX_CENTERS; i++) begin : g_lane
    nca_dist_lane u_lane (
      .clk_i      (clk_i),
      .en_i       (pipe_en),
      .point_x_i  (pt_x_q[0]),
      .point_y_i  (pt_y_q[0]),
      .center_x_i (ctr_x_q[i]),
      .center_y_i (ctr_y_q[i]),
      .dist_o     (lane_dist[i])
    );

    // lanes past the centre count take no part in the search
    assign leaf[i] = '{ok: lane_on[i], id: ID_W'(i), sq_dist: lane_dist[i]};
  end

  nca_min_tree u_tree (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .leaf_i (leaf),
    .win_o  (win)
  );

  // result word
  assign out_o.valid        = v_q[Stages-1];
  assign out_o.nearest_id   = win.id;
  assign out_o.min_distance = win.sq_dist;
  assign out_o.point_x      = pt_x_q[Stages-1];
  assign out_o.point_y      = pt_y_q[Stages-1];

  // a load leaving the input stage must never become a result
  a_load_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && (kind_q == KIND_LOAD) && rdy[1]) |=> !v_q[1])
    else $error("load word entered the distance stages");

  // centre zero always competes, so a delivered result has a real winner
  a_winner_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Stages-1] |-> win.ok)
    else $error("result word without a valid nearest centre");

  // an empty output stage must leave the input open
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[Stages-1] |-> in_i.ready)
    else $error("input stalled while output stage empty");

endmodule

>>> rtl/nca_dist_lane.sv
module nca_dist_lane import nca_pkg::*; (
  input  logic                  clk_i,
  input  pipe_en_t              en_i,
  input  logic [COORD_BITS-1:0] point_x_i,
  input  logic [COORD_BITS-1:0] point_y_i,
  input  logic [COORD_BITS-1:0] center_x_i,
  input  logic [COORD_BITS-1:0] center_y_i,
  output logic [DIST_BITS-1:0]  dist_o
);

  logic [COORD_BITS-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [SQ_BITS-1:0]    sqx_q, sqy_q;
  logic [DIST_BITS-1:0]  dist_q;

  // absolute differences
  always_comb begin
    dx_d = (point_x_i >= center_x_i) ? (point_x_i - center_x_i) : (center_x_i - point_x_i);
    dy_d = (point_y_i >= center_y_i) ? (point_y_i - center_y_i) : (center_y_i - point_y_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    // one square per axis
    if (en_i.s2) begin
      sqx_q <= SQ_BITS'(dx_q) * SQ_BITS'(dx_q);
      sqy_q <= SQ_BITS'(dy_q) * SQ_BITS'(dy_q);
    end
    if (en_i.s3) begin
      dist_q <= DIST_BITS'(sqx_q) + DIST_BITS'(sqy_q);
    end
  end

  assign dist_o = dist_q;

endmodule

>>> rtl/nca_min_tree.sv
module nca_min_tree import nca_pkg::*; (
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  cand_t    leaf_i [MAX_CENTERS],
  output cand_t    win_o
);

  localparam int Levels   = $clog2(MAX_CENTERS);
  localparam int Leaves   = 1 << Levels;
  localparam int MidLevel = Levels / 2;
  localparam int MidCount = Leaves >> MidLevel;

  cand_t work_a [Leaves];
  cand_t work_b [MidCount];
  cand_t mid_q  [MidCount];
  cand_t win_q;

  // lower levels of the tree, in place
  always_comb begin
    for (int i = 0; i < Leaves; i++) begin
      if (i < MAX_CENTERS) begin
        work_a[i] = leaf_i[i];
      end else begin
        work_a[i] = '0;
      end
    end
    for (int l = 0; l < MidLevel; l++) begin
      for (int j = 0; j < Leaves / 2; j++) begin
        if (j < (Leaves >> (l + 1))) begin
          work_a[j] = cand_min(work_a[2*j], work_a[2*j+1]);
        end
      end
    end
  end

  // upper levels of the tree
  always_comb begin
    for (int i = 0; i < MidCount; i++) begin
      work_b[i] = mid_q[i];
    end
    for (int l = 0; l < Levels - MidLevel; l++) begin
      for (int j = 0; j < MidCount / 2; j++) begin
        if (j < (MidCount >> (l + 1))) begin
          work_b[j] = cand_min(work_b[2*j], work_b[2*j+1]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      for (int i = 0; i < MidCount; i++) begin
        mid_q[i] <= work_a[i];
      end
    end
    if (en_i.s5) begin
      win_q <= work_b[0];
    end
  end

  assign win_o = win_q;

endmodule
